[rtl/vhnn_pkg.sv]
// Package for the voxel hash nearest-neighbor block: types, codes and constants.
// Used by every module in rtl/; depends on nothing.
`default_nettype none
package vhnn_pkg;

  localparam int VOXEL_SLOTS_DEF       = 1024;
  localparam int MAX_BUCKET_POINTS_DEF = 32;
  localparam int MAX_RADIUS_DEF        = 2;
  localparam int MAX_K_DEF             = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int COORD_W     = 24;
  localparam int KEY_W       = 16;
  localparam int DIST_W      = 52;

  localparam logic [23:0] INV_RESET = 24'd65536;
  localparam logic [5:0]  CAP_RESET = 6'd20;
  localparam logic [1:0]  RAD_RESET = 2'd1;

  localparam logic [1:0] REG_INV = 2'd0;
  localparam logic [1:0] REG_CAP = 2'd1;
  localparam logic [1:0] REG_RAD = 2'd2;

  localparam logic [31:0] HASH_C0 = 32'd73856093;
  localparam logic [31:0] HASH_C1 = 32'd19349669;
  localparam logic [31:0] HASH_C2 = 32'd83492791;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_NEAREST = 2'd1,
    OP_KNN     = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BUCKET_FULL = 2'd1,
    ST_TABLE_FULL  = 2'd2,
    ST_NONE        = 2'd3
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [COORD_W-1:0] qz;
    logic [4:0]                want;
    logic [KEY_W-1:0]          bx;
    logic [KEY_W-1:0]          by;
    logic [KEY_W-1:0]          bz;
  } item_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_HMUL,
    BK_HMOD,
    BK_PRD,
    BK_PCHK,
    BK_INSERT,
    BK_SCAN,
    BK_DRAIN,
    BK_NEXT,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

[rtl/voxel_hash_nearest_neighbor.sv]
// Top level: APB registers, front end, request queue and search engine.
// An insert probes the voxel table for its voxel; a query visits up to (2r+1)^3 voxels,
// probing for each and scanning every stored point of an occupied one. Throughput: one
// request at a time in the engine; the queue holds two more and the front end a third.
// Reset: a pass over the voxel table, no request taken; clear repeats that pass.
// Depends on vhnn_pkg.
`default_nettype none
module voxel_hash_nearest_neighbor #(
  parameter int VOXEL_SLOTS       = vhnn_pkg::VOXEL_SLOTS_DEF,
  parameter int MAX_BUCKET_POINTS = vhnn_pkg::MAX_BUCKET_POINTS_DEF,
  parameter int MAX_RADIUS        = vhnn_pkg::MAX_RADIUS_DEF,
  parameter int MAX_K             = vhnn_pkg::MAX_K_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic signed [23:0] coord_x,
  input  wire logic signed [23:0] coord_y,
  input  wire logic signed [23:0] coord_z,
  input  wire logic [4:0]         want_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic signed [23:0]      near_x,
  output logic signed [23:0]      near_y,
  output logic signed [23:0]      near_z,
  output logic [51:0]             dist_squared,
  output logic                    last
);

  logic [23:0]       inverse_voxel_size;
  logic [5:0]        bucket_capacity;
  logic [1:0]        search_radius;
  logic              init_busy, q_wr, q_full, q_rd, q_empty;
  vhnn_pkg::item_t   q_wdata, q_rdata;
  vhnn_pkg::status_t status_code;

  assign pready = 1'b1;
  assign status = status_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_voxel_size <= vhnn_pkg::INV_RESET;
      bucket_capacity    <= vhnn_pkg::CAP_RESET;
      search_radius      <= vhnn_pkg::RAD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        vhnn_pkg::REG_INV: inverse_voxel_size <= pwdata[23:0];
        vhnn_pkg::REG_CAP: bucket_capacity    <= pwdata[5:0];
        vhnn_pkg::REG_RAD: search_radius      <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      vhnn_pkg::REG_INV: prdata = {8'd0, inverse_voxel_size};
      vhnn_pkg::REG_CAP: prdata = {26'd0, bucket_capacity};
      vhnn_pkg::REG_RAD: prdata = {30'd0, search_radius};
      default:           prdata = '0;
    endcase
  end

  vhnn_front u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .kind               (kind),
    .coord_x            (coord_x),
    .coord_y            (coord_y),
    .coord_z            (coord_z),
    .want_count         (want_count),
    .inverse_voxel_size (inverse_voxel_size),
    .init_busy          (init_busy),
    .q_wr               (q_wr),
    .q_wdata            (q_wdata),
    .q_full             (q_full)
  );

  vhnn_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  vhnn_back #(
    .VOXEL_SLOTS       (VOXEL_SLOTS),
    .MAX_BUCKET_POINTS (MAX_BUCKET_POINTS),
    .MAX_RADIUS        (MAX_RADIUS),
    .MAX_K             (MAX_K)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .bucket_capacity (bucket_capacity),
    .search_radius   (search_radius),
    .init_busy       (init_busy),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_rd            (q_rd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status_code),
    .near_x          (near_x),
    .near_y          (near_y),
    .near_z          (near_z),
    .dist_squared    (dist_squared),
    .last            (last)
  );

endmodule
`default_nettype wire

[rtl/vhnn_front.sv]
// Front end: accepts requests and computes their voxel indices, one axis a cycle.
// Depends on vhnn_pkg; feeds vhnn_queue.
`default_nettype none
module vhnn_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            kind,
  input  wire logic signed [23:0]    coord_x,
  input  wire logic signed [23:0]    coord_y,
  input  wire logic signed [23:0]    coord_z,
  input  wire logic [4:0]            want_count,
  input  wire logic [23:0]           inverse_voxel_size,
  input  wire logic                  init_busy,
  output logic                       q_wr,
  output vhnn_pkg::item_t            q_wdata,
  input  wire logic                  q_full
);

  vhnn_pkg::front_state_t state, state_next;
  vhnn_pkg::item_t        item;
  logic [1:0]             step;
  logic signed [23:0]     coord_sel;
  logic signed [48:0]     prod;

  always_comb begin
    unique case (step)
      2'd0:    coord_sel = item.qx;
      2'd1:    coord_sel = item.qy;
      default: coord_sel = item.qz;
    endcase
    prod = coord_sel * $signed({1'b0, inverse_voxel_size});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vhnn_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    q_wr       = 1'b0;
    unique case (state)
      vhnn_pkg::FR_IDLE: begin
        in_ready = !init_busy;
        if (in_valid && !init_busy) state_next = vhnn_pkg::FR_MUL;
      end
      vhnn_pkg::FR_MUL: begin
        if (step == 2'd2) state_next = vhnn_pkg::FR_PUSH;
      end
      vhnn_pkg::FR_PUSH: begin
        q_wr = !q_full;
        if (!q_full) state_next = vhnn_pkg::FR_IDLE;
      end
      default: state_next = vhnn_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == vhnn_pkg::FR_IDLE && in_valid && !init_busy) begin
      item.op   <= vhnn_pkg::op_t'(kind);
      item.qx   <= coord_x;
      item.qy   <= coord_y;
      item.qz   <= coord_z;
      item.want <= want_count;
      step      <= 2'd0;
    end else if (state == vhnn_pkg::FR_MUL) begin
      unique case (step)
        2'd0:    item.bx <= prod[41:26];
        2'd1:    item.by <= prod[41:26];
        default: item.bz <= prod[41:26];
      endcase
      step <= step + 2'd1;
    end
  end

  assign q_wdata = item;

endmodule
`default_nettype wire

[rtl/vhnn_queue.sv]
// Short request queue between the front end and the search engine.
// Depends on vhnn_pkg for the entry type and depth.
`default_nettype none
module vhnn_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire vhnn_pkg::item_t wdata,
  output logic                 full,
  input  wire logic            rd,
  output vhnn_pkg::item_t      rdata,
  output logic                 empty
);

  localparam int QW = (vhnn_pkg::QUEUE_DEPTH > 1) ? $clog2(vhnn_pkg::QUEUE_DEPTH) : 1;

  vhnn_pkg::item_t    mem [vhnn_pkg::QUEUE_DEPTH];
  logic [QW-1:0]      wptr, rptr;
  logic [QW:0]        count;

  assign full  = (count == (QW+1)'(vhnn_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == QW'(vhnn_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == QW'(vhnn_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (QW+1)'(wr) - (QW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

endmodule
`default_nettype wire

[rtl/vhnn_back.sv]
// Search engine: voxel table, point store, hash probing, distance pipeline,
// sorted candidate list and result register. Depends on vhnn_pkg.
`default_nettype none
module vhnn_back #(
  parameter int VOXEL_SLOTS       = vhnn_pkg::VOXEL_SLOTS_DEF,
  parameter int MAX_BUCKET_POINTS = vhnn_pkg::MAX_BUCKET_POINTS_DEF,
  parameter int MAX_RADIUS        = vhnn_pkg::MAX_RADIUS_DEF,
  parameter int MAX_K             = vhnn_pkg::MAX_K_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [5:0]         bucket_capacity,
  input  wire logic [1:0]         search_radius,
  output logic                    init_busy,
  input  wire logic               q_empty,
  input  wire vhnn_pkg::item_t    q_rdata,
  output logic                    q_rd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output vhnn_pkg::status_t       status,
  output logic signed [23:0]      near_x,
  output logic signed [23:0]      near_y,
  output logic signed [23:0]      near_z,
  output logic [51:0]             dist_squared,
  output logic                    last
);

  localparam int SLOT_W = $clog2(VOXEL_SLOTS);
  localparam int PN_W   = $clog2(VOXEL_SLOTS + 1);
  localparam int FILL_W = $clog2(MAX_BUCKET_POINTS + 1);
  localparam int KW     = $clog2(MAX_K + 1);
  localparam int PA_W   = $clog2(VOXEL_SLOTS * MAX_BUCKET_POINTS);
  localparam int KEYM_W = 1 + 3 * vhnn_pkg::KEY_W + FILL_W;

  vhnn_pkg::back_state_t state, state_next;
  vhnn_pkg::op_t         op;
  vhnn_pkg::status_t     ins_status;
  logic                  ins_do;
  logic                  clr_after;

  logic signed [23:0]    qx, qy, qz;
  logic [15:0]           bx, by, bz, kx, ky, kz;
  logic signed [2:0]     ox, oy, oz, rr;
  logic [1:0]            r_cur, r_lim;
  logic [KW-1:0]         k_lim, k_new, ei;

  logic [SLOT_W-1:0]     swp, h, slot;
  logic [PN_W-1:0]       pn;
  logic [1:0]            step;
  logic [2:0]            mod_cnt;
  logic [31:0]           acc, hprod;
  logic [SLOT_W:0]       rem, rem4;
  logic [FILL_W-1:0]     fill_n, idx;

  logic [KEYM_W-1:0]     key_mem [VOXEL_SLOTS];
  logic [KEYM_W-1:0]     key_rdata, key_wdata;
  logic [SLOT_W-1:0]     key_waddr, key_raddr;
  logic                  key_we;
  logic [71:0]           pt_mem [VOXEL_SLOTS * MAX_BUCKET_POINTS];
  logic [71:0]           pt_rdata;
  logic [PA_W-1:0]       pt_waddr, pt_raddr;
  logic                  pt_we, scan_issue;

  logic                  kv, kmatch, probe_end;
  logic [FILL_W-1:0]     rfill;
  logic [6:0]            cap7, fill7;

  logic                  v1, v2, v3;
  logic [71:0]           p2, p3;
  logic [49:0]           sq0, sq1, sq2;
  logic [51:0]           d3;

  logic [71:0]           bl_p [MAX_K];
  logic [51:0]           bl_d [MAX_K];
  logic [KW-1:0]         bl_cnt;
  logic [MAX_K-1:0]      gt;
  logic                  gt_last, ins_ok;

  logic                  out_load, final_res;
  logic [71:0]           sel_p;
  logic [51:0]           sel_d;

  assign init_busy = (state == vhnn_pkg::BK_SWEEP) && !clr_after;
  assign rr = {1'b0, r_cur};
  assign kx = bx + {{13{ox[2]}}, ox};
  assign ky = by + {{13{oy[2]}}, oy};
  assign kz = bz + {{13{oz[2]}}, oz};
  assign r_lim = (int'(search_radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : search_radius;
  assign k_new = (q_rdata.op == vhnn_pkg::OP_NEAREST) ? KW'(1) :
                 (int'(q_rdata.want) > MAX_K) ? KW'(MAX_K) : KW'(q_rdata.want);

  assign kv     = key_rdata[KEYM_W-1];
  assign kmatch = key_rdata[KEYM_W-2 -: 3*vhnn_pkg::KEY_W] == {kx, ky, kz};
  assign rfill  = key_rdata[FILL_W-1:0];
  assign probe_end = !kv || kmatch || (pn == PN_W'(VOXEL_SLOTS - 1));
  assign cap7  = (7'(bucket_capacity) > 7'(MAX_BUCKET_POINTS)) ? 7'(MAX_BUCKET_POINTS)
                                                               : 7'(bucket_capacity);
  assign fill7 = (kv && kmatch) ? 7'(rfill) : 7'd0;

  always_comb begin
    unique case (step)
      2'd0:    hprod = 32'(kx * vhnn_pkg::HASH_C0);
      2'd1:    hprod = 32'(ky * vhnn_pkg::HASH_C1);
      default: hprod = 32'(kz * vhnn_pkg::HASH_C2);
    endcase
  end

  always_comb begin
    rem4 = rem;
    for (int j = 0; j < 4; j++) begin
      rem4 = {rem4[SLOT_W-1:0], acc[31-j]};
      if (rem4 >= (SLOT_W+1)'(VOXEL_SLOTS)) rem4 = rem4 - (SLOT_W+1)'(VOXEL_SLOTS);
    end
  end

  always_comb begin
    gt_last = 1'b0;
    for (int i = 0; i < MAX_K; i++) begin
      gt[i] = (i < int'(bl_cnt)) && (bl_d[i] > d3);
      if (i == int'(k_lim) - 1) gt_last = gt[i];
    end
    ins_ok = (bl_cnt < k_lim) || gt_last;
  end

  always_comb begin
    sel_p = '0;
    sel_d = '0;
    for (int i = 0; i < MAX_K; i++) begin
      if (i == int'(ei)) begin
        sel_p = bl_p[i];
        sel_d = bl_d[i];
      end
    end
  end

  assign final_res = (op != vhnn_pkg::OP_KNN) || (ei == bl_cnt - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vhnn_pkg::BK_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    key_we     = 1'b0;
    key_waddr  = swp;
    key_wdata  = '0;
    key_raddr  = h;
    pt_we      = 1'b0;
    pt_waddr   = PA_W'(slot) * PA_W'(MAX_BUCKET_POINTS) + PA_W'(fill_n);
    pt_raddr   = PA_W'(slot) * PA_W'(MAX_BUCKET_POINTS) + PA_W'(idx);
    scan_issue = 1'b0;
    q_rd       = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      vhnn_pkg::BK_SWEEP: begin
        key_we = 1'b1;
        if (swp == SLOT_W'(VOXEL_SLOTS - 1)) begin
          state_next = clr_after ? vhnn_pkg::BK_EMIT : vhnn_pkg::BK_IDLE;
        end
      end
      vhnn_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          priority if (q_rdata.op == vhnn_pkg::OP_CLEAR) begin
            state_next = vhnn_pkg::BK_SWEEP;
          end else if (q_rdata.op == vhnn_pkg::OP_KNN && k_new == '0) begin
            state_next = vhnn_pkg::BK_IDLE;
          end else begin
            state_next = vhnn_pkg::BK_HMUL;
          end
        end
      end
      vhnn_pkg::BK_HMUL: begin
        if (step == 2'd2) state_next = vhnn_pkg::BK_HMOD;
      end
      vhnn_pkg::BK_HMOD: begin
        if (mod_cnt == 3'd7) state_next = vhnn_pkg::BK_PRD;
      end
      vhnn_pkg::BK_PRD: begin
        state_next = vhnn_pkg::BK_PCHK;
      end
      vhnn_pkg::BK_PCHK: begin
        priority if (!probe_end) begin
          state_next = vhnn_pkg::BK_PRD;
        end else if (op == vhnn_pkg::OP_INSERT) begin
          state_next = vhnn_pkg::BK_INSERT;
        end else if (kv && kmatch && rfill != '0) begin
          state_next = vhnn_pkg::BK_SCAN;
        end else begin
          state_next = vhnn_pkg::BK_NEXT;
        end
      end
      vhnn_pkg::BK_INSERT: begin
        key_we    = ins_do;
        key_waddr = slot;
        key_wdata = {1'b1, kx, ky, kz, FILL_W'(fill_n + 1'b1)};
        pt_we     = ins_do;
        state_next = vhnn_pkg::BK_EMIT;
      end
      vhnn_pkg::BK_SCAN: begin
        scan_issue = 1'b1;
        if (idx == fill_n - 1'b1) state_next = vhnn_pkg::BK_DRAIN;
      end
      vhnn_pkg::BK_DRAIN: begin
        if (!v1 && !v2 && !v3) state_next = vhnn_pkg::BK_NEXT;
      end
      vhnn_pkg::BK_NEXT: begin
        if (ox == rr && oy == rr && oz == rr) state_next = vhnn_pkg::BK_EMIT;
        else state_next = vhnn_pkg::BK_HMUL;
      end
      vhnn_pkg::BK_EMIT: begin
        if (!out_valid || out_ready) begin
          if (op == vhnn_pkg::OP_KNN && bl_cnt == '0) begin
            state_next = vhnn_pkg::BK_IDLE;
          end else begin
            out_load = 1'b1;
            if (final_res) state_next = vhnn_pkg::BK_IDLE;
          end
        end
      end
      default: state_next = vhnn_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    key_rdata <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= {qx, qy, qz};
    pt_rdata <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swp       <= '0;
      clr_after <= 1'b0;
      bl_cnt    <= '0;
      k_lim     <= '0;
    end else begin
      unique case (state)
        vhnn_pkg::BK_SWEEP: begin
          swp <= swp + 1'b1;
        end
        vhnn_pkg::BK_IDLE: begin
          if (!q_empty) begin
            op        <= q_rdata.op;
            qx        <= q_rdata.qx;
            qy        <= q_rdata.qy;
            qz        <= q_rdata.qz;
            bx        <= q_rdata.bx;
            by        <= q_rdata.by;
            bz        <= q_rdata.bz;
            k_lim     <= k_new;
            bl_cnt    <= '0;
            ei        <= '0;
            step      <= 2'd0;
            swp       <= '0;
            r_cur     <= r_lim;
            clr_after <= (q_rdata.op == vhnn_pkg::OP_CLEAR);
            if (q_rdata.op == vhnn_pkg::OP_INSERT) begin
              ox <= '0;
              oy <= '0;
              oz <= '0;
            end else begin
              ox <= -$signed({1'b0, r_lim});
              oy <= -$signed({1'b0, r_lim});
              oz <= -$signed({1'b0, r_lim});
            end
          end
        end
        vhnn_pkg::BK_HMUL: begin
          acc  <= (step == 2'd0) ? hprod : (acc ^ hprod);
          step <= step + 2'd1;
          rem     <= '0;
          mod_cnt <= '0;
        end
        vhnn_pkg::BK_HMOD: begin
          acc     <= {acc[27:0], 4'd0};
          rem     <= rem4;
          mod_cnt <= mod_cnt + 3'd1;
          h       <= rem4[SLOT_W-1:0];
          pn      <= '0;
        end
        vhnn_pkg::BK_PCHK: begin
          slot   <= h;
          fill_n <= FILL_W'(fill7);
          idx    <= '0;
          if (!probe_end) begin
            h  <= (h == SLOT_W'(VOXEL_SLOTS - 1)) ? '0 : h + 1'b1;
            pn <= pn + 1'b1;
          end
          ins_do <= 1'b0;
          priority if (kv && !kmatch) begin
            ins_status <= (cap7 != '0) ? vhnn_pkg::ST_TABLE_FULL : vhnn_pkg::ST_BUCKET_FULL;
          end else if (fill7 >= cap7) begin
            ins_status <= vhnn_pkg::ST_BUCKET_FULL;
          end else begin
            ins_status <= vhnn_pkg::ST_OK;
            ins_do     <= 1'b1;
          end
        end
        vhnn_pkg::BK_SCAN: begin
          idx <= idx + 1'b1;
        end
        vhnn_pkg::BK_NEXT: begin
          step <= 2'd0;
          if (oz != rr) begin
            oz <= oz + 3'sd1;
          end else begin
            oz <= -rr;
            if (oy != rr) begin
              oy <= oy + 3'sd1;
            end else begin
              oy <= -rr;
              ox <= ox + 3'sd1;
            end
          end
        end
        vhnn_pkg::BK_EMIT: begin
          if (out_load) ei <= ei + 1'b1;
        end
        default: begin
        end
      endcase
      if (v3 && ins_ok && bl_cnt < k_lim) bl_cnt <= bl_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= scan_issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [24:0] dxs, dys, dzs;
    dxs = $signed({pt_rdata[71], pt_rdata[71:48]}) - $signed({qx[23], qx});
    dys = $signed({pt_rdata[47], pt_rdata[47:24]}) - $signed({qy[23], qy});
    dzs = $signed({pt_rdata[23], pt_rdata[23:0]}) - $signed({qz[23], qz});
    if (v1) begin
      p2  <= pt_rdata;
      sq0 <= 50'(dxs * dxs);
      sq1 <= 50'(dys * dys);
      sq2 <= 50'(dzs * dzs);
    end
    if (v2) begin
      p3 <= p2;
      d3 <= 52'(sq0) + 52'(sq1) + 52'(sq2);
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && ins_ok) begin
      for (int i = 0; i < MAX_K; i++) begin
        if (i > 0 && gt[i > 0 ? i - 1 : 0]) begin
          bl_p[i] <= bl_p[i > 0 ? i - 1 : 0];
          bl_d[i] <= bl_d[i > 0 ? i - 1 : 0];
        end else if ((gt[i] || i == int'(bl_cnt)) && !(i > 0 && gt[i > 0 ? i - 1 : 0])) begin
          bl_p[i] <= p3;
          bl_d[i] <= d3;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      last <= final_res;
      unique case (op)
        vhnn_pkg::OP_INSERT: begin
          status       <= ins_status;
          {near_x, near_y, near_z} <= {qx, qy, qz};
          dist_squared <= '0;
        end
        vhnn_pkg::OP_CLEAR: begin
          status       <= vhnn_pkg::ST_OK;
          {near_x, near_y, near_z} <= '0;
          dist_squared <= '0;
        end
        vhnn_pkg::OP_NEAREST: begin
          if (bl_cnt == '0) begin
            status       <= vhnn_pkg::ST_NONE;
            {near_x, near_y, near_z} <= '0;
            dist_squared <= '1;
          end else begin
            status       <= vhnn_pkg::ST_OK;
            {near_x, near_y, near_z} <= sel_p;
            dist_squared <= sel_d;
          end
        end
        default: begin
          status       <= vhnn_pkg::ST_OK;
          {near_x, near_y, near_z} <= sel_p;
          dist_squared <= sel_d;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) bl_cnt <= k_lim)
    else $error("candidate count above limit");
  a_pipe_scan: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (state == vhnn_pkg::BK_SCAN || state == vhnn_pkg::BK_DRAIN))
    else $error("distance pipeline busy outside a bucket scan");
  a_out_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == vhnn_pkg::BK_EMIT))
    else $error("result loaded outside emit");
  a_scan_fill: assert property (@(posedge clk) disable iff (rst)
    (state == vhnn_pkg::BK_SCAN) |-> fill_n != '0)
    else $error("scan of an empty bucket");

endmodule
`default_nettype wire

[bench/voxel_hash_nearest_neighbor_tb.sv]
// Self-checking bench for voxel_hash_nearest_neighbor: drives inserts, queries and clears,
// predicts results with a behavioral copy of the voxel table and compares them in order.
// Depends on vhnn_pkg and the rtl/ modules.
`default_nettype none
module voxel_hash_nearest_neighbor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 1024;
  localparam int MAXPTS = 32;
  localparam int MAXK = 16;

  typedef struct {
    vhnn_pkg::op_t kind;
    logic signed [23:0] x, y, z;
    logic [4:0] want;
  } request_t;

  typedef struct {
    vhnn_pkg::status_t st;
    logic signed [23:0] x, y, z;
    logic [51:0] d;
    logic last;
  } answer_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic [1:0] kind = 0;
  logic signed [23:0] coord_x = 0, coord_y = 0, coord_z = 0;
  logic [4:0] want_count = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] status;
  logic signed [23:0] near_x, near_y, near_z;
  logic [51:0] dist_squared;
  logic last;

  voxel_hash_nearest_neighbor uut (.*);

  initial forever #1 clk = ~clk;
  initial begin
    #200000000;
    $display("voxel_hash_nearest_neighbor test failed");
    $finish;
  end

  logic [23:0] inv_size = 24'd65536;
  logic [5:0] capacity = 6'd20;
  logic [1:0] radius = 2'd1;
  bit slot_used[SLOTS];
  logic [15:0] slot_key[SLOTS][3];
  int slot_fill[SLOTS];
  logic signed [23:0] slot_pts[SLOTS][MAXPTS][3];
  logic signed [23:0] best_pt[MAXK][3];
  logic [51:0] best_d[MAXK];
  int best_n;

  request_t pending_requests[$];
  answer_t expected_answers[$];
  int mismatches = 0;
  bit driver_idle = 1;

  function automatic logic [15:0] voxel_of(logic signed [23:0] c);
    logic signed [63:0] prod;
    prod = 64'(c) * $signed({40'd0, inv_size});
    return 16'((prod + (64'sd1 <<< 48)) >>> 26);
  endfunction

  function automatic int find_slot(logic [15:0] k0, k1, k2, output int slot);
    logic [31:0] h;
    h = (32'(k0) * vhnn_pkg::HASH_C0) ^ (32'(k1) * vhnn_pkg::HASH_C1) ^
        (32'(k2) * vhnn_pkg::HASH_C2);
    h = h % SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      slot = int'(h);
      if (!slot_used[h]) return 0;
      if (slot_key[h][0] == k0 && slot_key[h][1] == k1 && slot_key[h][2] == k2) return 1;
      h = (h + 1) % SLOTS;
    end
    return -1;
  endfunction

  function automatic void gather_nearest(request_t r, int k);
    int rr, slot, pos;
    logic [15:0] b0, b1, b2;
    logic [51:0] d;
    logic signed [31:0] df;
    rr = radius > 2 ? 2 : radius;
    best_n = 0;
    b0 = voxel_of(r.x); b1 = voxel_of(r.y); b2 = voxel_of(r.z);
    for (int dx = -rr; dx <= rr; dx++)
      for (int dy = -rr; dy <= rr; dy++)
        for (int dz = -rr; dz <= rr; dz++) begin
          if (find_slot(16'(b0 + dx), 16'(b1 + dy), 16'(b2 + dz), slot) != 1) continue;
          for (int i = 0; i < slot_fill[slot]; i++) begin
            d = 0;
            df = slot_pts[slot][i][0] - r.x; d += 52'(64'(df) * 64'(df));
            df = slot_pts[slot][i][1] - r.y; d += 52'(64'(df) * 64'(df));
            df = slot_pts[slot][i][2] - r.z; d += 52'(64'(df) * 64'(df));
            if (best_n < k) begin
              pos = best_n;
              best_n++;
            end else if (d < best_d[k-1]) pos = k - 1;
            else continue;
            while (pos > 0 && best_d[pos-1] > d) begin
              best_d[pos] = best_d[pos-1];
              best_pt[pos] = best_pt[pos-1];
              pos--;
            end
            best_d[pos] = d;
            best_pt[pos] = slot_pts[slot][i];
          end
        end
  endfunction

  function automatic void predict_results(request_t r);
    answer_t a;
    int slot, found, cap, k;
    a = '{vhnn_pkg::ST_OK, 0, 0, 0, 0, 1};
    case (r.kind)
      vhnn_pkg::OP_INSERT: begin
        cap = capacity > MAXPTS ? MAXPTS : capacity;
        found = find_slot(voxel_of(r.x), voxel_of(r.y), voxel_of(r.z), slot);
        if (found < 0 && cap > 0) a.st = vhnn_pkg::ST_TABLE_FULL;
        else if (found < 0 || slot_fill[slot] >= cap) a.st = vhnn_pkg::ST_BUCKET_FULL;
        else begin
          if (found == 0) begin
            slot_used[slot] = 1;
            slot_key[slot] = '{voxel_of(r.x), voxel_of(r.y), voxel_of(r.z)};
            slot_fill[slot] = 0;
          end
          slot_pts[slot][slot_fill[slot]] = '{r.x, r.y, r.z};
          slot_fill[slot]++;
        end
        a.x = r.x; a.y = r.y; a.z = r.z;
        expected_answers.push_back(a);
      end
      vhnn_pkg::OP_NEAREST: begin
        gather_nearest(r, 1);
        if (best_n == 0) begin
          a.st = vhnn_pkg::ST_NONE; a.d = '1;
        end else begin
          a.x = best_pt[0][0]; a.y = best_pt[0][1]; a.z = best_pt[0][2]; a.d = best_d[0];
        end
        expected_answers.push_back(a);
      end
      vhnn_pkg::OP_KNN: begin
        k = r.want > MAXK ? MAXK : r.want;
        if (k > 0) begin
          gather_nearest(r, k);
          for (int i = 0; i < best_n; i++) begin
            a.x = best_pt[i][0]; a.y = best_pt[i][1]; a.z = best_pt[i][2];
            a.d = best_d[i]; a.last = (i + 1 == best_n);
            expected_answers.push_back(a);
          end
        end
      end
      default: begin
        for (int s = 0; s < SLOTS; s++) begin
          slot_used[s] = 0; slot_fill[s] = 0;
        end
        expected_answers.push_back(a);
      end
    endcase
  endfunction

  int send_wait = 0;

  // driver: accept at posedge, change at negedge
  bit taken;
  always @(posedge clk) taken <= in_valid && in_ready;
  always @(negedge clk) begin
    request_t r;
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !taken) begin
    end else if (send_wait > 0) begin
      in_valid <= 0;
      send_wait <= send_wait - 1;
    end else if (pending_requests.size() > 0) begin
      r = pending_requests.pop_front();
      predict_results(r);
      in_valid <= 1;
      kind <= r.kind; coord_x <= r.x; coord_y <= r.y; coord_z <= r.z; want_count <= r.want;
      send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    end else begin
      in_valid <= 0;
    end
    driver_idle <= !(in_valid && !taken) && pending_requests.size() == 0 && send_wait == 0;
  end

  int stall = 0;
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if (out_ready && out_valid) begin
      stall = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) stall = 0;
      out_ready <= stall == 0;
    end else if (!out_ready) begin
      if (stall > 0) stall--;
      out_ready <= stall == 0;
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status %0d", status);
      end else begin
        e = expected_answers.pop_front();
        if (status !== e.st || near_x !== e.x || near_y !== e.y || near_z !== e.z ||
            dist_squared !== e.d || last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                     e.st, e.x, e.y, e.z, e.d, e.last,
                     status, near_x, near_y, near_z, dist_squared, last);
        end
      end
    end
  end

  task automatic apb_write(logic [3:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (addr)
      4'd0: inv_size = data[23:0];
      4'd4: capacity = data[5:0];
      default: radius = data[1:0];
    endcase
  endtask

  task automatic drain;
    wait (pending_requests.size() == 0);
    @(negedge clk);
    wait (driver_idle && !in_valid && expected_answers.size() == 0);
    repeat (3000) @(posedge clk);
  endtask

  function automatic logic signed [23:0] pick_coord(int spread);
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  task automatic add_request(vhnn_pkg::op_t k, logic signed [23:0] x, y, z, logic [4:0] w);
    request_t r;
    r = '{k, x, y, z, w};
    pending_requests.push_back(r);
  endtask

  task automatic random_phase(int n, int spread);
    vhnn_pkg::op_t k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: k = vhnn_pkg::OP_INSERT;
        10, 11, 12, 13: k = vhnn_pkg::OP_NEAREST;
        19: k = vhnn_pkg::OP_CLEAR;
        default: k = vhnn_pkg::OP_KNN;
      endcase
      add_request(k, pick_coord(spread), pick_coord(spread), pick_coord(spread),
                  5'($urandom_range(0, 31)));
    end
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s] = 0; slot_fill[s] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 0;
    repeat (SLOTS + 20) @(posedge clk);

    add_request(vhnn_pkg::OP_NEAREST, 0, 0, 0, 0);
    add_request(vhnn_pkg::OP_KNN, 0, 0, 0, 5);
    add_request(vhnn_pkg::OP_INSERT, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0);
    add_request(vhnn_pkg::OP_INSERT, 24'sh800000, 24'sh800000, 24'sh800000, 31);
    add_request(vhnn_pkg::OP_INSERT, 100, 200, 300, 0);
    add_request(vhnn_pkg::OP_INSERT, 100, 200, 300, 0);
    add_request(vhnn_pkg::OP_INSERT, -100, 50, 1000, 0);
    add_request(vhnn_pkg::OP_INSERT, 1500, -1500, 20, 0);
    add_request(vhnn_pkg::OP_NEAREST, 100, 200, 300, 0);
    add_request(vhnn_pkg::OP_NEAREST, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0);
    add_request(vhnn_pkg::OP_KNN, 0, 0, 0, 0);
    add_request(vhnn_pkg::OP_KNN, 0, 0, 0, 31);
    add_request(vhnn_pkg::OP_KNN, 200, 100, 300, 3);
    for (int i = 0; i < 22; i++) add_request(vhnn_pkg::OP_INSERT, 5 * i, 7, 9, 0);
    add_request(vhnn_pkg::OP_KNN, 10, 7, 9, 16);
    add_request(vhnn_pkg::OP_CLEAR, 24'sh555555, 24'shAAAAAA, 0, 31);
    add_request(vhnn_pkg::OP_NEAREST, 100, 200, 300, 0);
    drain();

    apb_write(4'd4, 32'd1);
    apb_write(4'd8, 32'd0);
    apb_write(4'd0, 32'd16777215);
    random_phase(60, 5000);
    drain();

    apb_write(4'd0, 32'd1);
    apb_write(4'd4, 32'd0);
    add_request(vhnn_pkg::OP_INSERT, 3, 4, 5, 0);
    add_request(vhnn_pkg::OP_CLEAR, 0, 0, 0, 0);
    drain();
    apb_write(4'd4, 32'd63);
    apb_write(4'd8, 32'd3);
    random_phase(80, 3000);
    drain();

    apb_write(4'd0, 32'd0);
    apb_write(4'd8, 32'd2);
    random_phase(30, 2000);
    drain();

    apb_write(4'd0, 32'd65536);
    apb_write(4'd4, 32'd20);
    apb_write(4'd8, 32'd1);
    add_request(vhnn_pkg::OP_CLEAR, 0, 0, 0, 0);
    random_phase(100, 2048);
    drain();

    apb_write(4'd0, 32'd8192);
    apb_write(4'd4, 32'd32);
    apb_write(4'd8, 32'd2);
    random_phase(90, 4000);
    drain();

    if (mismatches == 0) $display("voxel_hash_nearest_neighbor test passed");
    else $display("voxel_hash_nearest_neighbor test failed");
    $finish;
  end
endmodule
`default_nettype wire

[voxel_hash_nearest_neighbor.f]
rtl/vhnn_pkg.sv
rtl/vhnn_front.sv
rtl/vhnn_queue.sv
rtl/vhnn_back.sv
rtl/voxel_hash_nearest_neighbor.sv
bench/voxel_hash_nearest_neighbor_tb.sv
